[hdl/lkvc_pkg.sv]
// Shared types and constants for the LRU key/value cache.
package lkvc_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int CAP_W   = 5;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;

  typedef struct packed {
    logic        opcode;
    logic [31:0] lookup_key;
    logic [31:0] store_value;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [31:0] read_value;
  } rsp_t;

endpackage

[hdl/lru_key_value_cache.sv]
// LRU key/value cache: tags and ranks in flops, values in a synchronous RAM.
//
// A get that misses returns its result in the next cycle; a get that hits
// goes through S_READ, where the registered read of the value RAM is moved
// into the output register. A new item is taken only in S_IDLE, and only if
// the output register is empty or its result is being transferred.
module lru_key_value_cache
  import lkvc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  req_t             in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output rsp_t             out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic             state;
  logic [CAP_W-1:0] capacity;
  logic [CNT_W-1:0] occ;
  logic [ENTRIES-1:0] valid;
  logic [31:0]      tag  [ENTRIES];
  logic [IDX_W-1:0] rank [ENTRIES];
  logic [31:0]      mem  [ENTRIES];
  logic [31:0]      rd_data;

  logic             accept;
  logic             out_load;
  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  logic             free_ok;
  logic [IDX_W-1:0] free_idx;
  logic             vic_ok;
  logic [IDX_W-1:0] vic_idx;
  logic [CNT_W-1:0] cap_eff;
  logic [IDX_W-1:0] occ_last;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept    = in_valid && in_ready;
  assign out_load  = (state == S_READ) || (accept && in_data.opcode == OP_GET && !hit);
  assign cap_eff   = (capacity > CAP_W'(ENTRIES)) ? CNT_W'(ENTRIES) : CNT_W'(capacity);
  assign occ_last  = IDX_W'(occ - CNT_W'(1));

  always_comb begin
    hit = 1'b0; hit_idx = '0;
    free_ok = 1'b0; free_idx = '0;
    vic_ok = 1'b0; vic_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid[i] && tag[i] == in_data.lookup_key) begin
        hit = 1'b1; hit_idx = IDX_W'(i);
      end
      if (!valid[i]) begin
        free_ok = 1'b1; free_idx = IDX_W'(i);
      end
      if (valid[i] && rank[i] == occ_last && occ != '0) begin
        vic_ok = 1'b1; vic_idx = IDX_W'(i);
      end
    end
  end

  // promote: entry becomes most recent; insert: fresh entry, all others age
  logic             promote, insert, wr_en;
  logic [IDX_W-1:0] tgt;

  always_comb begin
    promote = 1'b0; insert = 1'b0; wr_en = 1'b0; tgt = hit_idx;
    if (accept) begin
      if (hit) begin
        promote = 1'b1;
        wr_en   = (in_data.opcode == OP_PUT);
      end else if (in_data.opcode == OP_PUT) begin
        if (occ < cap_eff) begin
          insert = free_ok; wr_en = free_ok; tgt = free_idx;
        end else if (vic_ok) begin
          promote = 1'b1; wr_en = 1'b1; tgt = vic_idx;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[tgt] <= in_data.store_value;
    rd_data <= mem[hit_idx];
  end

  always_ff @(posedge clk) begin
    if (wr_en) tag[tgt] <= in_data.lookup_key;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      capacity <= CAP_W'(16);
      occ      <= '0;
      valid    <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) rank[i] <= '0;
    end else begin
      if (cfg_valid && cfg_ready) capacity <= cfg_data;
      if (out_valid && out_ready && !out_load) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept && in_data.opcode == OP_GET) begin
            if (hit) begin
              state <= S_READ;
            end else begin
              out_valid <= 1'b1;
              out_data  <= '{found: 1'b0, read_value: MISS_VALUE};
            end
          end
        end
        S_READ: begin
          out_valid <= 1'b1;
          out_data  <= '{found: 1'b1, read_value: rd_data};
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (promote) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid[i] && IDX_W'(i) != tgt && rank[i] < rank[tgt])
            rank[i] <= rank[i] + IDX_W'(1);
        end
        rank[tgt] <= '0;
      end
      if (insert) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid[i]) rank[i] <= rank[i] + IDX_W'(1);
        end
        rank[tgt]  <= '0;
        valid[tgt] <= 1'b1;
        occ        <= occ + CNT_W'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= CNT_W'(ENTRIES)) else $error("occupancy above entry count");
  a_occ_match: assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == int'(occ)) else $error("occupancy differs from valid bits");
  a_read_out: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |=> out_valid && out_data.found)
    else $error("hit read gave no result");
  a_no_take: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |-> !in_ready) else $error("item taken during value read");
`endif

endmodule
